>>> design/frl_pkg.sv
// shared types and constants for the force update rate limiter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frl_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [23:0] AccMax   = 24'hFF_FFFF;
  localparam logic [7:0]  FrameMax = 8'hFF;

  localparam logic [8:0]  RstSmoothingQ8  = 9'd77;
  localparam logic [14:0] RstMaxLevel     = 15'd10000;
  localparam logic [15:0] RstJumpMagLimit = 16'd400;
  localparam logic [15:0] RstJumpDirLimit = 16'd2000;
  localparam logic [23:0] RstAccMagLimit  = 24'd300;
  localparam logic [23:0] RstAccDirLimit  = 24'd1500;
  localparam logic [7:0]  RstTimeout      = 8'd12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SMOOTHING_Q8    = 3'd0,
    REG_MAX_LEVEL       = 3'd1,
    REG_JUMP_MAG_LIMIT  = 3'd2,
    REG_JUMP_DIR_LIMIT  = 3'd3,
    REG_ACCUM_MAG_LIMIT = 3'd4,
    REG_ACCUM_DIR_LIMIT = 3'd5,
    REG_TIMEOUT_FRAMES  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0]  smoothing_q8;
    logic [14:0] max_level;
    logic [15:0] jump_mag_limit;
    logic [15:0] jump_dir_limit;
    logic [23:0] accum_mag_limit;
    logic [23:0] accum_dir_limit;
    logic [7:0]  timeout_frames;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic               send;
  } result_t;

endpackage

`default_nettype wire

>>> design/frl_cfg.sv
// configuration register file of the force update rate limiter
// depends on frl_pkg
`timescale 1ns / 1ps
`default_nettype none

module frl_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [frl_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [frl_pkg::CfgDataW-1:0]  cfg_data,
  output frl_pkg::cfg_t                      cfg
);
  import frl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_q8    <= RstSmoothingQ8;
      cfg.max_level       <= RstMaxLevel;
      cfg.jump_mag_limit  <= RstJumpMagLimit;
      cfg.jump_dir_limit  <= RstJumpDirLimit;
      cfg.accum_mag_limit <= RstAccMagLimit;
      cfg.accum_dir_limit <= RstAccDirLimit;
      cfg.timeout_frames  <= RstTimeout;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SMOOTHING_Q8:    cfg.smoothing_q8    <= cfg_data[8:0];
        REG_MAX_LEVEL:       cfg.max_level       <= cfg_data[14:0];
        REG_JUMP_MAG_LIMIT:  cfg.jump_mag_limit  <= cfg_data[15:0];
        REG_JUMP_DIR_LIMIT:  cfg.jump_dir_limit  <= cfg_data[15:0];
        REG_ACCUM_MAG_LIMIT: cfg.accum_mag_limit <= cfg_data[23:0];
        REG_ACCUM_DIR_LIMIT: cfg.accum_dir_limit <= cfg_data[23:0];
        REG_TIMEOUT_FRAMES:  cfg.timeout_frames  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/frl_update.sv
// per-item smoothing, change accumulation and send decision with its state
// depends on frl_pkg
`timescale 1ns / 1ps
`default_nettype none

module frl_update (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic signed [15:0]   cmd,
  input  wire logic signed [1:0]    fsign,
  input  frl_pkg::cfg_t             cfg,
  output frl_pkg::result_t          result
);
  import frl_pkg::*;

  function automatic logic [16:0] abs18(input logic signed [17:0] d);
    logic [17:0] n;
    begin
      n = d[17] ? (18'd0 - d) : d;
      return n[16:0];
    end
  endfunction

  logic signed [15:0] smoothed_dir;
  logic signed [16:0] sent_mag;
  logic signed [15:0] sent_dir;
  logic signed [16:0] prev_mag;
  logic [7:0]         frame_count;
  logic [23:0]        accum_mag;
  logic [23:0]        accum_dir;

  logic signed [16:0] target;
  logic signed [17:0] dir_err;
  logic signed [27:0] prod;
  logic signed [27:0] num;
  logic signed [19:0] quot;
  logic signed [15:0] smoothed_dir_next;
  logic [16:0]        mag;
  logic [16:0]        step_mag;
  logic [16:0]        step_dir;
  logic [16:0]        jump_mag;
  logic [24:0]        sum_mag;
  logic [24:0]        sum_dir;
  logic [23:0]        accum_mag_next;
  logic [23:0]        accum_dir_next;
  logic [7:0]         frame_count_next;
  logic               none_sent;
  logic               sign_change;
  logic               fire;

  always_comb begin
    if (fsign == 2'sb00) begin
      target = '0;
    end else if (fsign == 2'sb01) begin
      target = 17'sd0 - $signed({2'b00, cfg.max_level});
    end else begin
      target = $signed({2'b00, cfg.max_level});
    end

    dir_err = $signed({{2{smoothed_dir[15]}}, smoothed_dir}) - $signed({target[16], target});
    prod    = $signed({1'b0, cfg.smoothing_q8}) * dir_err;
    num     = $signed({{3{target[16]}}, target, 8'h00}) + prod;
    // truncate toward zero
    quot    = num[27:8] + ((num[27] && (num[7:0] != 8'h00)) ? 20'sd1 : 20'sd0);
    if (quot[19:15] != {5{quot[15]}}) begin
      smoothed_dir_next = quot[19] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      smoothed_dir_next = quot[15:0];
    end

    mag = cmd[15] ? (17'd0 - {cmd[15], cmd}) : {1'b0, cmd};

    none_sent = (sent_mag == -17'sd1);
    step_mag  = abs18($signed({1'b0, mag}) - $signed({prev_mag[16], prev_mag}));
    step_dir  = abs18($signed({{2{smoothed_dir_next[15]}}, smoothed_dir_next})
                      - $signed({{2{sent_dir[15]}}, sent_dir}));
    jump_mag  = abs18($signed({1'b0, mag}) - $signed({sent_mag[16], sent_mag}));

    sum_mag = {1'b0, accum_mag} + {8'h00, step_mag};
    sum_dir = {1'b0, accum_dir} + {8'h00, step_dir};
    if (none_sent) begin
      accum_mag_next = accum_mag;
      accum_dir_next = accum_dir;
    end else begin
      accum_mag_next = sum_mag[24] ? AccMax : sum_mag[23:0];
      accum_dir_next = sum_dir[24] ? AccMax : sum_dir[23:0];
    end

    frame_count_next = (frame_count == FrameMax) ? frame_count : frame_count + 8'd1;

    sign_change = (sent_dir[15] != smoothed_dir_next[15]) ||
                  ((sent_dir == 16'sd0) != (smoothed_dir_next == 16'sd0));

    fire = (jump_mag >= {1'b0, cfg.jump_mag_limit}) ||
           (step_dir >= {1'b0, cfg.jump_dir_limit}) ||
           (accum_mag_next >= cfg.accum_mag_limit) ||
           (accum_dir_next >= cfg.accum_dir_limit) ||
           sign_change ||
           (frame_count_next >= cfg.timeout_frames) ||
           ((mag == 17'd0) && (sent_mag != 17'sd0));

    result.send      = fire;
    result.out_value = fire ? cmd : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_dir <= '0;
      sent_mag     <= -17'sd1;
      sent_dir     <= '0;
      prev_mag     <= -17'sd1;
      frame_count  <= '0;
      accum_mag    <= '0;
      accum_dir    <= '0;
    end else if (advance) begin
      smoothed_dir <= smoothed_dir_next;
      prev_mag     <= $signed(mag);
      if (fire) begin
        sent_mag    <= $signed(mag);
        sent_dir    <= smoothed_dir_next;
        frame_count <= '0;
        accum_mag   <= '0;
        accum_dir   <= '0;
      end else begin
        frame_count <= frame_count_next;
        accum_mag   <= accum_mag_next;
        accum_dir   <= accum_dir_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/force_update_rate_limiter_core.sv
// top level of the force update rate limiter: input register, result register
// depends on frl_pkg, frl_cfg, frl_update
`timescale 1ns / 1ps
`default_nettype none

// One force frame per item, one item per clock sustained while the result side
// does not stall. An accepted item sits in the input register while the
// smoothing multiply, the change accumulators and the send decision are
// evaluated and the state is updated. The result is registered: an item goes
// through the input register and then the result register, where it is read.
// The result register frees the input side: a new item is accepted whenever the
// result register is empty or being read in the same cycle. Configuration writes
// are always ready and take effect on the next item; write them only while idle.
module force_update_rate_limiter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output      logic                          item_stall,
  input  wire logic signed [15:0]            signed_magnitude,
  input  wire logic signed [1:0]             force_sign,
  output      logic                          result_valid,
  input  wire logic                          result_stall,
  output      logic signed [15:0]            out_value,
  output      logic                          send,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [frl_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [frl_pkg::CfgDataW-1:0]  cfg_data
);
  import frl_pkg::*;

  cfg_t               cfg;
  result_t            result;
  logic               item_q_valid;
  logic signed [15:0] item_q_cmd;
  logic signed [1:0]  item_q_sign;
  logic               advance;
  logic               item_take;

  assign cfg_ready  = 1'b1;
  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;
  assign item_take  = item_valid && !item_stall;

  frl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  frl_update u_update (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cmd     (item_q_cmd),
    .fsign   (item_q_sign),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_take) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      item_q_cmd  <= signed_magnitude;
      item_q_sign <= force_sign;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= result.out_value;
      send      <= result.send;
    end
  end

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("processed item did not reach the result register");

  a_quiet_result_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !send) |-> (out_value == 16'sd0))
    else $error("unsent result carries a nonzero value");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (item_q_valid && result_valid && result_stall))
    else $error("input stalled without a blocked item");

endmodule

`default_nettype wire
